// File: sv/rnft_pkg.sv
package rnft_pkg;

   // field types
   typedef logic        [7:0]  rssi_raw_type;
   typedef logic        [31:0] tick_type;
   typedef logic signed [7:0]  dbm_type;
   typedef logic        [3:0]  margin_type;
   typedef logic signed [11:0] avg_x16_type;
   typedef logic        [1:0]  csr_index_type;
   typedef logic        [7:0]  csr_data_type;

   // register indexes
   localparam csr_index_type CSR_BUSY_MARGIN   = 2'd0;
   localparam csr_index_type CSR_DEFAULT_FLOOR = 2'd1;

   // register reset values
   localparam margin_type MARGIN_RESET        = 4'd6;
   localparam dbm_type    DEFAULT_FLOOR_RESET = -8'sd110;

   // radio and floor constants
   localparam logic signed [9:0] RSSI_OFFSET = 10'sd157;
   localparam dbm_type    FLOOR_MIN      = -8'sd127;
   localparam dbm_type    FLOOR_MAX      = 8'sd0;
   localparam margin_type MARGIN_DEFAULT = 4'd6;
   localparam margin_type MARGIN_LOW     = 4'd6;
   localparam margin_type MARGIN_HIGH    = 4'd10;

   // clamp a wide signed value to the floor range
   function automatic dbm_type clamp_floor(input logic signed [12:0] v);
      dbm_type r;
      if (v < 13'(FLOOR_MIN)) begin
         r = FLOOR_MIN;
      end else if (v > 13'(FLOOR_MAX)) begin
         r = FLOOR_MAX;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

   // margin values outside the allowed span fall back to the default
   function automatic margin_type effective_margin(input margin_type m);
      margin_type r;
      if ((m < MARGIN_LOW) || (m > MARGIN_HIGH)) begin
         r = MARGIN_DEFAULT;
      end else begin
         r = m;
      end
      return r;
   endfunction

endpackage

// File: sv/rssi_noise_floor_tracker_core.sv
// Noise floor tracker for a radio receiver.
// Request channel (req_): one transfer per RSSI reading, carrying the raw
// RSSI byte, the current millisecond tick and an eligibility flag.
// Response channel (rsp_): one transfer per request, carrying the floor after
// the update, the seeded flag, the busy threshold, the busy decision made
// against the threshold as it stood before the update, and whether the
// reading was folded into the average.
// Configuration channel (csr_): always ready; index 0 is the busy margin,
// index 1 the default floor used until the first sample. Write it only
// while no request is in flight.
// A request passes through one input register, then the averaging logic
// feeding the response register. Throughput is one request per cycle while
// the receiver does not stall; the state update lives in a single stage,
// so consecutive readings chain through it without gaps.
// When the receiver stalls, the response holds and the input register keeps
// its reading; req_stall rises only once both are full.
// Synchronous reset empties both registers, clears the average and restores
// the register defaults.
module rssi_noise_floor_tracker_core #(
   parameter int unsigned SAMPLE_INTERVAL_MS = 100
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rnft_pkg::rssi_raw_type req_rssi_raw,
   input  rnft_pkg::tick_type     req_now_ms,
   input  logic                   req_sample_ok,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rnft_pkg::dbm_type      rsp_floor_dbm,
   output logic                   rsp_floor_valid,
   output rnft_pkg::dbm_type      rsp_threshold_dbm,
   output logic                   rsp_channel_busy,
   output logic                   rsp_sample_taken,
   // configuration channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  rnft_pkg::csr_index_type csr_index,
   input  rnft_pkg::csr_data_type  csr_wdata
);
   import rnft_pkg::*;

   // configuration registers
   margin_type margin_ff;
   dbm_type    dflt_floor_ff;

   // input stage
   logic         in_valid_ff, in_valid_in;
   rssi_raw_type in_raw_ff;
   tick_type     in_now_ff;
   logic         in_ok_ff;

   // tracker state
   avg_x16_type avg_ff,    avg_in;
   logic        seeded_ff, seeded_in;
   tick_type    last_ff,   last_in;
   dbm_type     floor_ff,  floor_in;

   // response stage
   logic    out_valid_ff, out_valid_in;
   dbm_type out_floor_ff, out_floor_in;
   logic    out_fvalid_ff;
   dbm_type out_thresh_ff, out_thresh_in;
   logic    out_busy_ff, out_busy_in;
   logic    out_taken_ff, out_taken_in;

   // datapath signals
   logic                  out_free;
   logic                  advance;
   logic signed [9:0]     rssi_dbm;
   margin_type            margin_eff;
   dbm_type               cur_floor;
   logic signed [9:0]     pre_thresh;
   tick_type              elapsed;
   logic                  take;
   dbm_type               sample;
   avg_x16_type           samp_scaled;
   logic signed [12:0]    diff;
   logic signed [12:0]    step;
   avg_x16_type           avg_upd;
   logic signed [12:0]    avg_wide;
   logic signed [12:0]    rounded;
   dbm_type               floor_upd;

   // handshake
   assign out_free     = !out_valid_ff || !rsp_stall;
   assign advance      = in_valid_ff && out_free;
   assign req_stall    = in_valid_ff && !out_free;
   assign in_valid_in  = (req_valid && !req_stall) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);
   assign csr_ready    = 1'b1;

   // pre-update floor, threshold and busy decision
   assign rssi_dbm   = $signed({2'b00, in_raw_ff}) - RSSI_OFFSET;
   assign margin_eff = effective_margin(margin_ff);
   assign cur_floor  = seeded_ff ? floor_ff : clamp_floor(13'(dflt_floor_ff));
   assign pre_thresh = 10'(cur_floor) + $signed({6'b000000, margin_eff});

   // sample interval check, modulo tick wrap
   assign elapsed = in_now_ff - last_ff;
   assign take    = in_ok_ff && (!seeded_ff || (elapsed >= 32'(SAMPLE_INTERVAL_MS)));

   // clamped sample in sixteenths
   assign sample      = clamp_floor(13'(rssi_dbm));
   assign samp_scaled = {sample[7:0], 4'b0000};

   // average step, divide by eight truncating toward zero
   assign diff = 13'(samp_scaled) - 13'(avg_ff);
   assign step = (diff < 13'sd0) ? ((diff + 13'sd7) >>> 3) : (diff >>> 3);
   assign avg_upd = 12'(13'(avg_ff) + step);

   // divide by sixteen, half away from zero, then clamp
   assign avg_wide = 13'(avg_upd);
   always_comb begin
      if (avg_wide >= 13'sd0) begin
         rounded = (avg_wide + 13'sd8) >>> 4;
      end else begin
         rounded = -((-avg_wide + 13'sd8) >>> 4);
      end
   end
   assign floor_upd = clamp_floor(rounded);

   // next state
   always_comb begin
      avg_in    = avg_ff;
      seeded_in = seeded_ff;
      last_in   = last_ff;
      floor_in  = floor_ff;
      if (advance && take) begin
         last_in   = in_now_ff;
         seeded_in = 1'b1;
         if (!seeded_ff) begin
            avg_in   = samp_scaled;
            floor_in = sample;
         end else begin
            avg_in   = avg_upd;
            floor_in = floor_upd;
         end
      end
   end

   // response fields, floor after the update
   assign out_floor_in  = seeded_in ? floor_in : clamp_floor(13'(dflt_floor_ff));
   assign out_thresh_in = out_floor_in + $signed({4'b0000, margin_eff});
   assign out_busy_in   = rssi_dbm >= pre_thresh;
   assign out_taken_in  = take;

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         avg_ff        <= '0;
         seeded_ff     <= 1'b0;
         last_ff       <= '0;
         floor_ff      <= '0;
         margin_ff     <= MARGIN_RESET;
         dflt_floor_ff <= DEFAULT_FLOOR_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         avg_ff       <= avg_in;
         seeded_ff    <= seeded_in;
         last_ff      <= last_in;
         floor_ff     <= floor_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BUSY_MARGIN:   margin_ff     <= csr_wdata[3:0];
               CSR_DEFAULT_FLOOR: dflt_floor_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // input payload register
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_raw_ff <= req_rssi_raw;
         in_now_ff <= req_now_ms;
         in_ok_ff  <= req_sample_ok;
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      if (advance) begin
         out_floor_ff  <= out_floor_in;
         out_fvalid_ff <= seeded_in;
         out_thresh_ff <= out_thresh_in;
         out_busy_ff   <= out_busy_in;
         out_taken_ff  <= out_taken_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_floor_dbm     = out_floor_ff;
   assign rsp_floor_valid   = out_fvalid_ff;
   assign rsp_threshold_dbm = out_thresh_ff;
   assign rsp_channel_busy  = out_busy_ff;
   assign rsp_sample_taken  = out_taken_ff;

endmodule

// File: sv/rnft_checker.sv
module rnft_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input rnft_pkg::dbm_type       rsp_floor_dbm,
   input logic                    rsp_floor_valid,
   input rnft_pkg::dbm_type       rsp_threshold_dbm,
   input logic                    rsp_sample_taken
);
   import rnft_pkg::*;

   // a stalled response holds its fields
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_floor_dbm)
         && $stable(rsp_threshold_dbm) && $stable(rsp_sample_taken))
      else $error("stalled response changed");

   // the cycle after reset nothing is offered
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   // a folded-in sample always leaves the average seeded
   a_taken_seeded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sample_taken |-> rsp_floor_valid)
      else $error("sample taken without seeded floor");

   // reported floor stays in range
   a_floor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_floor_dbm >= FLOOR_MIN) && (rsp_floor_dbm <= FLOOR_MAX))
      else $error("floor out of range");

   // threshold sits a legal margin above the floor
   a_margin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_threshold_dbm - rsp_floor_dbm >= 8'(MARGIN_LOW))
         && (rsp_threshold_dbm - rsp_floor_dbm <= 8'(MARGIN_HIGH)))
      else $error("threshold margin out of range");

endmodule

bind rssi_noise_floor_tracker_core rnft_checker u_rnft_checker (.*);

// File: tb/sv/tb_rssi_noise_floor_tracker_core.sv
module tb_rssi_noise_floor_tracker_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SAMPLE_INTERVAL_MS = 100;
   localparam int RANDOM_PER_PHASE = 282;
   localparam int PLAN_LEN = 33;

   // row kinds and how a row is checked
   localparam logic ROW_CSR  = 1'b1;
   localparam logic ROW_ITEM = 1'b0;
   localparam logic KNOWN    = 1'b1;
   localparam logic PREDICT  = 1'b0;

   // indexes that map to no register
   localparam rnft_pkg::csr_index_type CSR_SPARE_A = 2'd2;
   localparam rnft_pkg::csr_index_type CSR_SPARE_B = 2'd3;

   typedef struct packed {
      rnft_pkg::dbm_type floor_dbm;
      logic              floor_valid;
      rnft_pkg::dbm_type threshold_dbm;
      logic              channel_busy;
      logic              sample_taken;
   } floor_report_type;

   typedef struct packed {
      logic                    is_csr;
      rnft_pkg::csr_index_type csr_idx;
      rnft_pkg::csr_data_type  csr_data;
      rnft_pkg::rssi_raw_type  rssi_raw;
      rnft_pkg::tick_type      now_ms;
      logic                    sample_ok;
      logic                    checked_by;
      floor_report_type        report;
   } plan_row_type;

   // directed stimulus: register writes and readings in order
   plan_row_type directed_plan [0:PLAN_LEN-1] = '{
      // defaults after reset, busy compare on both sides of the threshold
      '{ROW_ITEM, '0, '0, 8'd0,   32'd0,   1'b0, KNOWN, '{-8'sd110, 1'b0, -8'sd104, 1'b0, 1'b0}},
      '{ROW_ITEM, '0, '0, 8'd255, 32'd0,   1'b0, KNOWN, '{-8'sd110, 1'b0, -8'sd104, 1'b1, 1'b0}},
      '{ROW_ITEM, '0, '0, 8'd53,  32'd500, 1'b0, KNOWN, '{-8'sd110, 1'b0, -8'sd104, 1'b1, 1'b0}},
      '{ROW_ITEM, '0, '0, 8'd52,  32'd500, 1'b0, KNOWN, '{-8'sd110, 1'b0, -8'sd104, 1'b0, 1'b0}},
      // top of the margin span
      '{ROW_CSR, rnft_pkg::CSR_BUSY_MARGIN, 8'd10, '0, '0, 1'b0, PREDICT, '0},
      '{ROW_ITEM, '0, '0, 8'd57,  32'd500, 1'b0, KNOWN, '{-8'sd110, 1'b0, -8'sd100, 1'b1, 1'b0}},
      '{ROW_ITEM, '0, '0, 8'd56,  32'd500, 1'b0, KNOWN, '{-8'sd110, 1'b0, -8'sd100, 1'b0, 1'b0}},
      // margins outside the span fall back
      '{ROW_CSR, rnft_pkg::CSR_BUSY_MARGIN, 8'd15, '0, '0, 1'b0, PREDICT, '0},
      '{ROW_ITEM, '0, '0, 8'd53,  32'd500, 1'b0, KNOWN, '{-8'sd110, 1'b0, -8'sd104, 1'b1, 1'b0}},
      '{ROW_CSR, rnft_pkg::CSR_BUSY_MARGIN, 8'd5, '0, '0, 1'b0, PREDICT, '0},
      '{ROW_ITEM, '0, '0, 8'd52,  32'd500, 1'b0, KNOWN, '{-8'sd110, 1'b0, -8'sd104, 1'b0, 1'b0}},
      // default floor below range is clamped
      '{ROW_CSR, rnft_pkg::CSR_DEFAULT_FLOOR, 8'h80, '0, '0, 1'b0, PREDICT, '0},
      '{ROW_CSR, rnft_pkg::CSR_BUSY_MARGIN, 8'd0, '0, '0, 1'b0, PREDICT, '0},
      '{ROW_ITEM, '0, '0, 8'd0,   32'd500, 1'b0, KNOWN, '{-8'sd127, 1'b0, -8'sd121, 1'b0, 1'b0}},
      '{ROW_ITEM, '0, '0, 8'd36,  32'd500, 1'b0, KNOWN, '{-8'sd127, 1'b0, -8'sd121, 1'b1, 1'b0}},
      // default floor above range is clamped
      '{ROW_CSR, rnft_pkg::CSR_DEFAULT_FLOOR, 8'h7F, '0, '0, 1'b0, PREDICT, '0},
      '{ROW_ITEM, '0, '0, 8'd163, 32'd500, 1'b0, KNOWN, '{8'sd0, 1'b0, 8'sd6, 1'b1, 1'b0}},
      '{ROW_ITEM, '0, '0, 8'd162, 32'd500, 1'b0, KNOWN, '{8'sd0, 1'b0, 8'sd6, 1'b0, 1'b0}},
      // writes to unmapped indexes change nothing
      '{ROW_CSR, rnft_pkg::CSR_DEFAULT_FLOOR, 8'h00, '0, '0, 1'b0, PREDICT, '0},
      '{ROW_CSR, CSR_SPARE_A, 8'h08, '0, '0, 1'b0, PREDICT, '0},
      '{ROW_CSR, CSR_SPARE_B, 8'hAA, '0, '0, 1'b0, PREDICT, '0},
      '{ROW_ITEM, '0, '0, 8'd162, 32'hFFFF_FFFF, 1'b0, KNOWN, '{8'sd0, 1'b0, 8'sd6, 1'b0, 1'b0}},
      // first sample at tick zero seeds the average
      '{ROW_CSR, rnft_pkg::CSR_BUSY_MARGIN, 8'd8, '0, '0, 1'b0, PREDICT, '0},
      '{ROW_CSR, rnft_pkg::CSR_DEFAULT_FLOOR, 8'h81, '0, '0, 1'b0, PREDICT, '0},
      '{ROW_ITEM, '0, '0, 8'd255, 32'd0,   1'b1, KNOWN, '{8'sd0, 1'b1, 8'sd8, 1'b1, 1'b1}},
      '{ROW_ITEM, '0, '0, 8'd0,   32'd99,  1'b1, KNOWN, '{8'sd0, 1'b1, 8'sd8, 1'b0, 1'b0}},
      '{ROW_ITEM, '0, '0, 8'd0,   32'd100, 1'b1, KNOWN, '{-8'sd16, 1'b1, -8'sd8, 1'b0, 1'b1}},
      '{ROW_ITEM, '0, '0, 8'd0,   32'd400, 1'b0, KNOWN, '{-8'sd16, 1'b1, -8'sd8, 1'b0, 1'b0}},
      // tick wrap around the interval boundary
      '{ROW_ITEM, '0, '0, 8'd149, 32'hFFFF_FFC0, 1'b1, PREDICT, '0},
      '{ROW_ITEM, '0, '0, 8'd200, 32'h0000_0023, 1'b1, PREDICT, '0},
      '{ROW_ITEM, '0, '0, 8'd200, 32'h0000_0024, 1'b1, PREDICT, '0},
      '{ROW_ITEM, '0, '0, 8'd157, 32'h0000_1000, 1'b1, PREDICT, '0},
      '{ROW_ITEM, '0, '0, 8'd100, 32'h0000_1063, 1'b1, PREDICT, '0}
   };

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   rnft_pkg::rssi_raw_type   req_rssi_raw = '0;
   rnft_pkg::tick_type       req_now_ms = '0;
   logic                     req_sample_ok = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   rnft_pkg::dbm_type        rsp_floor_dbm;
   logic                     rsp_floor_valid;
   rnft_pkg::dbm_type        rsp_threshold_dbm;
   logic                     rsp_channel_busy;
   logic                     rsp_sample_taken;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   rnft_pkg::csr_index_type  csr_index = '0;
   rnft_pkg::csr_data_type   csr_wdata = '0;

   // tracker state as the testbench sees it
   rnft_pkg::margin_type     margin_reg = rnft_pkg::MARGIN_RESET;
   rnft_pkg::dbm_type        default_floor_reg = rnft_pkg::DEFAULT_FLOOR_RESET;
   int                       avg_x16 = 0;
   logic                     seeded = 1'b0;
   rnft_pkg::tick_type       last_tick = '0;
   int                       floor_held = 0;

   floor_report_type         pending_reports [$];
   int                       report_errors = 0;
   int                       report_count = 0;
   int                       send_idle_pct = 0;
   int                       stall_pct = 0;

   rssi_noise_floor_tracker_core #(
      .SAMPLE_INTERVAL_MS(SAMPLE_INTERVAL_MS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rssi_raw(req_rssi_raw),
      .req_now_ms(req_now_ms),
      .req_sample_ok(req_sample_ok),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_floor_dbm(rsp_floor_dbm),
      .rsp_floor_valid(rsp_floor_valid),
      .rsp_threshold_dbm(rsp_threshold_dbm),
      .rsp_channel_busy(rsp_channel_busy),
      .rsp_sample_taken(rsp_sample_taken),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // limit the dBm value to the floor range
   function automatic int clip_dbm(input int v);
      if (v < int'(rnft_pkg::FLOOR_MIN)) begin
         return int'(rnft_pkg::FLOOR_MIN);
      end
      if (v > int'(rnft_pkg::FLOOR_MAX)) begin
         return int'(rnft_pkg::FLOOR_MAX);
      end
      return v;
   endfunction

   function automatic int margin_in_use();
      if (margin_reg < rnft_pkg::MARGIN_LOW || margin_reg > rnft_pkg::MARGIN_HIGH) begin
         return int'(rnft_pkg::MARGIN_DEFAULT);
      end
      return int'(margin_reg);
   endfunction

   function automatic int floor_in_use();
      return seeded ? floor_held : clip_dbm(int'(default_floor_reg));
   endfunction

   // busy decision on the old floor, then fold the reading into the average
   function automatic floor_report_type advance_floor(input rnft_pkg::rssi_raw_type raw,
                                                      input rnft_pkg::tick_type now_ms,
                                                      input logic ok);
      floor_report_type r;
      int rssi_dbm;
      int pre_threshold;
      int samp_scaled;
      int fl;
      rnft_pkg::tick_type elapsed;
      rssi_dbm = int'(raw) - int'(rnft_pkg::RSSI_OFFSET);
      pre_threshold = floor_in_use() + margin_in_use();
      elapsed = now_ms - last_tick;
      r.channel_busy = (rssi_dbm >= pre_threshold);
      r.sample_taken = ok && (!seeded || elapsed >= SAMPLE_INTERVAL_MS);
      if (r.sample_taken) begin
         samp_scaled = clip_dbm(rssi_dbm) * 16;
         last_tick = now_ms;
         if (!seeded) begin
            avg_x16 = samp_scaled;
            seeded = 1'b1;
            floor_held = samp_scaled / 16;
         end else begin
            // division truncates toward zero, rounding is half away from zero
            avg_x16 = avg_x16 + (samp_scaled - avg_x16) / 8;
            floor_held = clip_dbm(avg_x16 >= 0 ? (avg_x16 + 8) / 16 : (avg_x16 - 8) / 16);
         end
      end
      fl = floor_in_use();
      r.floor_dbm = 8'(fl);
      r.floor_valid = seeded;
      r.threshold_dbm = 8'(fl + margin_in_use());
      return r;
   endfunction

   // one reading transfer with random idle cycles ahead of it
   task automatic send_reading(input rnft_pkg::rssi_raw_type raw,
                               input rnft_pkg::tick_type now_ms,
                               input logic ok,
                               input logic checked_by,
                               input floor_report_type known_report);
      floor_report_type predicted;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rssi_raw <= raw;
      req_now_ms <= now_ms;
      req_sample_ok <= ok;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      predicted = advance_floor(raw, now_ms, ok);
      pending_reports.push_back(checked_by == KNOWN ? known_report : predicted);
   endtask

   // register write once the pipeline has drained
   task automatic write_register(input rnft_pkg::csr_index_type idx,
                                 input rnft_pkg::csr_data_type data);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      case (idx)
         rnft_pkg::CSR_BUSY_MARGIN: begin
            margin_reg = data[3:0];
         end
         rnft_pkg::CSR_DEFAULT_FLOOR: begin
            default_floor_reg = data;
         end
         default: begin
         end
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // compare each response transfer with the oldest prediction
   always @(posedge clock) begin
      floor_report_type got;
      floor_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_floor_dbm, rsp_floor_valid, rsp_threshold_dbm, rsp_channel_busy,
                 rsp_sample_taken};
         if (pending_reports.size() == 0) begin
            report_errors++;
            if (report_errors <= 10) begin
               $display("response %0d arrived with none outstanding", report_count);
            end
         end else begin
            want = pending_reports.pop_front();
            if (got !== want) begin
               report_errors++;
               if (report_errors <= 10) begin
                  $display("response %0d: floor %0d/%0d valid %0b/%0b threshold %0d/%0d %s",
                           report_count, want.floor_dbm, got.floor_dbm, want.floor_valid,
                           got.floor_valid, want.threshold_dbm, got.threshold_dbm,
                           "(expected/actual)");
                  $display("   busy %0b/%0b taken %0b/%0b", want.channel_busy,
                           got.channel_busy, want.sample_taken, got.sample_taken);
               end
            end
         end
         report_count++;
      end
   end

   // overall time limit
   initial begin
      #2000000;
      $display("rssi_noise_floor_tracker_core: mismatch");
      $finish;
   end

   initial begin
      int phase;
      int k;
      int roll;
      int wait_cycles;
      rnft_pkg::tick_type tick;
      rnft_pkg::rssi_raw_type raw;
      logic ok;
      rnft_pkg::csr_data_type margin_w;
      rnft_pkg::csr_data_type floor_w;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (k = 0; k < PLAN_LEN; k++) begin
         if (directed_plan[k].is_csr == ROW_CSR) begin
            write_register(directed_plan[k].csr_idx, directed_plan[k].csr_data);
         end else begin
            send_reading(directed_plan[k].rssi_raw, directed_plan[k].now_ms,
                         directed_plan[k].sample_ok, directed_plan[k].checked_by,
                         directed_plan[k].report);
         end
      end

      // random readings under several idling patterns and settings
      tick = 32'h0000_1063;
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               margin_w = 8'd10;
               floor_w = 8'h80;
            end
            1: begin
               margin_w = 8'd0;
               floor_w = 8'h7F;
            end
            2: begin
               margin_w = 8'd15;
               floor_w = 8'h00;
            end
            default: begin
               margin_w = 8'($urandom_range(0, 255));
               floor_w = 8'($urandom_range(0, 255));
            end
         endcase
         write_register(rnft_pkg::CSR_BUSY_MARGIN, margin_w);
         write_register(rnft_pkg::CSR_DEFAULT_FLOOR, floor_w);
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 87;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 87;
            end
            default: begin
               send_idle_pct = 15;
               stall_pct = 15;
            end
         endcase
         for (k = 0; k < RANDOM_PER_PHASE; k++) begin
            // occasional margin change, sometimes to an unmapped index
            if (k % 70 == 69) begin
               roll = $urandom_range(0, 99);
               if (roll < 70) begin
                  write_register(rnft_pkg::CSR_BUSY_MARGIN, 8'($urandom_range(0, 255)));
               end else if (roll < 85) begin
                  write_register(CSR_SPARE_A, 8'($urandom_range(0, 255)));
               end else begin
                  write_register(CSR_SPARE_B, 8'($urandom_range(0, 255)));
               end
            end
            // mostly a steady tick near the interval, some jumps anywhere
            roll = $urandom_range(0, 99);
            if (roll < 80) begin
               tick = tick + $urandom_range(0, 160);
            end else if (roll < 90) begin
               tick = $urandom();
            end else begin
               tick = tick + $urandom_range(95, 105);
            end
            if ($urandom_range(0, 99) < 75) begin
               raw = 8'($urandom_range(20, 170));
            end else begin
               raw = 8'($urandom_range(0, 255));
            end
            ok = ($urandom_range(0, 99) < 75);
            send_reading(raw, tick, ok, PREDICT, '0);
         end
      end

      // drain
      @(negedge clock);
      req_valid <= 1'b0;
      for (wait_cycles = 0; wait_cycles < 50000 && pending_reports.size() != 0;
           wait_cycles++) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
      if (report_errors == 0 && pending_reports.size() == 0) begin
         $display("rssi_noise_floor_tracker_core: match");
      end else begin
         $display("rssi_noise_floor_tracker_core: mismatch");
      end
      $finish;
   end

endmodule
